// ===== sv/md3_pkg.sv =====
package md3_pkg;

  localparam int FRAMES_PER_BLOCK_DEF = 195;
  localparam int CHANNEL_COUNT_DEF    = 2;
  localparam int RING_DEPTH_DEF       = 16384;

  localparam int RAW_W      = 24;
  localparam int SAMPLE_W   = 18;
  localparam int SAMPLE_LSB = 6;
  localparam int SUM_W      = 20;
  localparam int PROD_W     = 2 * SUM_W;
  localparam int PCM_W      = 16;
  localparam int SLOT_W     = 14;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam int              DIV3_SHIFT = 21;
  localparam logic [SUM_W-1:0] DIV3_MULT = 20'd699051;

  localparam logic [SAMPLE_W-1:0]    SAT_POS_MAG = 18'd32767;
  localparam logic [SAMPLE_W-1:0]    SAT_NEG_MAG = 18'd32768;
  localparam logic signed [PCM_W-1:0] PCM_MAX    = 16'sh7fff;
  localparam logic signed [PCM_W-1:0] PCM_MIN    = 16'sh8000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_THIRD  = 3'b100
  } phase_t;

endpackage

// ===== sv/md3_front.sv =====
module md3_front
  import md3_pkg::*;
#(
  parameter int FRAMES_PER_BLOCK = FRAMES_PER_BLOCK_DEF,
  parameter int CHANNEL_COUNT    = CHANNEL_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [RAW_W-1:0] raw_word,
  input  qstat_t           q_stat,
  output logic             q_push,
  output sample_t          q_sample
);

  localparam int CW          = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int FW          = $clog2(FRAMES_PER_BLOCK);
  localparam int USED_FRAMES = ((FRAMES_PER_BLOCK - 3) / 3) * 3;

  logic [CW-1:0] chan;
  logic [FW-1:0] frame;
  logic          accept;
  logic          used;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign used     = (chan == '0) && (frame < FW'(USED_FRAMES));
  assign q_push   = accept && used;
  assign q_sample = sample_t'(raw_word[SAMPLE_LSB +: SAMPLE_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      chan  <= '0;
      frame <= '0;
    end else if (accept) begin
      if (chan == CW'(CHANNEL_COUNT - 1)) begin
        chan <= '0;
        if (frame == FW'(FRAMES_PER_BLOCK - 1)) begin
          frame <= '0;
        end else begin
          frame <= frame + 1'b1;
        end
      end else begin
        chan <= chan + 1'b1;
      end
    end
  end

endmodule

// ===== sv/md3_queue.sv =====
module md3_queue
  import md3_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  sample_t push_sample,
  input  logic    pop,
  output sample_t head_sample,
  output qstat_t  stat
);

  sample_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign stat.full   = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty  = (count == '0);
  assign head_sample = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/md3_back.sv =====
module md3_back
  import md3_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  qstat_t                   q_stat,
  input  sample_t                  q_sample,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [PCM_W-1:0]  pcm_sample,
  output logic [SLOT_W-1:0]        ring_slot
);

  localparam int RW = $clog2(RING_DEPTH);

  phase_t                   phase;
  logic signed [SUM_W-1:0]  partial_sum;
  logic signed [SUM_W-1:0]  s1_sum;
  logic                     s1_valid;
  logic                     s2_neg;
  logic [SAMPLE_W-1:0]      s2_mag;
  logic                     s2_valid;
  logic [RW-1:0]            ring_pos;

  logic                     out_ready;
  logic                     s2_ready;
  logic                     s1_ready;
  logic                     s1_take;
  logic                     s2_take;
  logic                     last_of_triple;
  logic signed [SUM_W-1:0]  sum_next;
  logic [SUM_W-1:0]         abs_sum;
  logic [PROD_W-1:0]        product;
  logic signed [PCM_W-1:0]  pcm_next;

  assign out_ready      = !out_valid || !out_stall;
  assign s2_ready       = !s2_valid || out_ready;
  assign s1_ready       = !s1_valid || s2_ready;
  assign s1_take        = s1_valid && s2_ready;
  assign s2_take        = s2_valid && out_ready;
  assign last_of_triple = (phase == PH_THIRD);
  assign q_pop          = !q_stat.empty && (!last_of_triple || s1_ready);
  assign sum_next       = partial_sum + SUM_W'(q_sample);

  assign abs_sum = s1_sum[SUM_W-1] ? SUM_W'(-s1_sum) : SUM_W'(s1_sum);
  assign product = PROD_W'(abs_sum) * PROD_W'(DIV3_MULT);

  always_comb begin
    if (s2_neg) begin
      pcm_next = (s2_mag > SAT_NEG_MAG) ? PCM_MIN : -PCM_W'(s2_mag);
    end else begin
      pcm_next = (s2_mag > SAT_POS_MAG) ? PCM_MAX : PCM_W'(s2_mag);
    end
  end

  // accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_FIRST;
      partial_sum <= '0;
    end else if (q_pop) begin
      unique case (phase)
        PH_FIRST: begin
          phase       <= PH_SECOND;
          partial_sum <= sum_next;
        end
        PH_SECOND: begin
          phase       <= PH_THIRD;
          partial_sum <= sum_next;
        end
        PH_THIRD: begin
          phase       <= PH_FIRST;
          partial_sum <= '0;
        end
        default: begin
          phase       <= PH_FIRST;
          partial_sum <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_pop && last_of_triple) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && last_of_triple) begin
      s1_sum <= sum_next;
    end
  end

  // divide magnitude by three
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_take) begin
      s2_valid <= 1'b1;
    end else if (s2_take) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s2_neg <= s1_sum[SUM_W-1];
      s2_mag <= product[DIV3_SHIFT +: SAMPLE_W];
    end
  end

  // saturate and emit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ring_pos  <= '0;
    end else begin
      if (s2_take) begin
        out_valid <= 1'b1;
        if (ring_pos == RW'(RING_DEPTH - 1)) begin
          ring_pos <= '0;
        end else begin
          ring_pos <= ring_pos + 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      pcm_sample <= pcm_next;
      ring_slot  <= SLOT_W'(ring_pos);
    end
  end

endmodule

// ===== sv/mic_decimate_by_three_core.sv =====
// The third sample of a triple passes the queue, then the s1_sum, s2_mag and pcm_sample
// registers. Throughput: 1 request per cycle sustained while in_stall is low; one result
// per 3 used left words. The 4-entry sample queue between front and back lets the input
// keep flowing while the output stalls, until the queue is full.
// Reset (rst, synchronous, active high) clears the block counter, the triple
// accumulator, the ring position, the queue and all valid flags.
module mic_decimate_by_three_core
  import md3_pkg::*;
#(
  parameter int FRAMES_PER_BLOCK = FRAMES_PER_BLOCK_DEF,
  parameter int CHANNEL_COUNT    = CHANNEL_COUNT_DEF,
  parameter int RING_DEPTH       = RING_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [RAW_W-1:0]        raw_word,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [PCM_W-1:0] pcm_sample,
  output logic [SLOT_W-1:0]       ring_slot
);

  qstat_t  q_stat;
  logic    q_push;
  logic    q_pop;
  sample_t push_sample;
  sample_t head_sample;

  md3_front #(
    .FRAMES_PER_BLOCK (FRAMES_PER_BLOCK),
    .CHANNEL_COUNT    (CHANNEL_COUNT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .raw_word (raw_word),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_sample (push_sample)
  );

  md3_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (q_push),
    .push_sample (push_sample),
    .pop         (q_pop),
    .head_sample (head_sample),
    .stat        (q_stat)
  );

  md3_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .q_sample   (head_sample),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pcm_sample (pcm_sample),
    .ring_slot  (ring_slot)
  );

endmodule

// ===== sv/md3_checker.sv =====
module md3_checker
  import md3_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [PCM_W-1:0] pcm_sample,
  input logic [SLOT_W-1:0]       ring_slot
);

  localparam int RW = $clog2(RING_DEPTH);

  logic [RW-1:0] expected_slot;
  logic          out_fire;

  assign out_fire = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_slot <= '0;
    end else if (out_fire) begin
      if (expected_slot == RW'(RING_DEPTH - 1)) begin
        expected_slot <= '0;
      end else begin
        expected_slot <= expected_slot + 1'b1;
      end
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pcm_sample) && $stable(ring_slot))
    else $error("stalled result changed");

  a_slot_sequence: assert property (@(posedge clk) disable iff (rst)
    out_fire |-> ring_slot == SLOT_W'(expected_slot))
    else $error("ring slot out of sequence");

  a_input_moves: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !$past(out_valid) && !$past(out_valid, 2) && !$past(out_valid, 3)
      && !$past(out_valid, 4) && !$past(rst, 4) && !$past(rst, 3) |-> !in_stall)
    else $error("input stalled with idle output");

endmodule

bind mic_decimate_by_three_core md3_checker #(
  .RING_DEPTH (RING_DEPTH)
) u_md3_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .pcm_sample (pcm_sample),
  .ring_slot  (ring_slot)
);

// ===== tb/sv/pcm_average_checker.sv =====
`timescale 1ns / 100ps

module pcm_average_checker
  import md3_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [RAW_W-1:0]        raw_word,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [PCM_W-1:0] pcm_sample,
  input  logic [SLOT_W-1:0]       ring_slot,
  output int                      mismatches,
  output int                      outstanding
);

  localparam int WORDS_PER_BLOCK = FRAMES_PER_BLOCK_DEF * CHANNEL_COUNT_DEF;
  localparam int USED_FRAMES     = ((FRAMES_PER_BLOCK_DEF - 3) / 3) * 3;

  typedef struct packed {
    logic signed [PCM_W-1:0] pcm;
    logic [SLOT_W-1:0]       slot;
  } decimated_t;

  decimated_t  due_samples[$];
  int unsigned word_pos;
  int unsigned triple_count;
  int          triple_sum;
  int unsigned next_slot;
  int          errors = 0;

  task automatic absorb_word(input logic [RAW_W-1:0] word);
    sample_t    sample;
    int         quotient;
    decimated_t result;
    sample = sample_t'(word[SAMPLE_LSB +: SAMPLE_W]);
    if ((word_pos % CHANNEL_COUNT_DEF) == 0 && (word_pos / CHANNEL_COUNT_DEF) < USED_FRAMES) begin
      triple_sum += sample;
      triple_count++;
      if (triple_count == 3) begin
        quotient = triple_sum / 3;
        if (quotient > int'(PCM_MAX)) begin
          result.pcm = PCM_MAX;
        end else if (quotient < int'(PCM_MIN)) begin
          result.pcm = PCM_MIN;
        end else begin
          result.pcm = quotient[PCM_W-1:0];
        end
        result.slot = next_slot[SLOT_W-1:0];
        due_samples.push_back(result);
        next_slot    = (next_slot + 1 == RING_DEPTH_DEF) ? 0 : next_slot + 1;
        triple_sum   = 0;
        triple_count = 0;
      end
    end
    word_pos = (word_pos + 1 == WORDS_PER_BLOCK) ? 0 : word_pos + 1;
  endtask

  task automatic check_sample();
    decimated_t want;
    if (due_samples.size() == 0) begin
      $display("%0t: unexpected sample, expected none, got pcm_sample %0d ring_slot %0d",
               $time, pcm_sample, ring_slot);
      errors++;
    end else begin
      want = due_samples.pop_front();
      if (pcm_sample !== want.pcm) begin
        $display("%0t: pcm_sample expected %0d, got %0d", $time, want.pcm, pcm_sample);
        errors++;
      end
      if (ring_slot !== want.slot) begin
        $display("%0t: ring_slot expected %0d, got %0d", $time, want.slot, ring_slot);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      due_samples.delete();
      word_pos     = 0;
      triple_count = 0;
      triple_sum   = 0;
      next_slot    = 0;
    end else begin
      if (out_valid && !out_stall) check_sample();
      if (in_valid && !in_stall) absorb_word(raw_word);
    end
    mismatches  <= errors;
    outstanding <= due_samples.size();
  end

endmodule

// ===== tb/sv/mic_decimate_by_three_core_test.sv =====
`timescale 1ns / 100ps

module mic_decimate_by_three_core_test
  import md3_pkg::*;
();

  localparam int STUCK_LIMIT = 2000;
  localparam int PHASES      = 4;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [RAW_W-1:0]        raw_word = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [PCM_W-1:0] pcm_sample;
  logic [SLOT_W-1:0]       ring_slot;
  int                      mismatches;
  int                      outstanding;
  int                      idle_pct = 0;
  int                      stall_pct = 0;
  int                      stuck_cycles;

  int corner_samples[12] = '{131071, 131071, 131071, -131072, -131072, -131072,
                             -1, -1, 0, 32768, 32768, 32768};

  int phase_idle[PHASES]  = '{0, 53, 0, 11};
  int phase_stall[PHASES] = '{0, 0, 53, 11};
  int phase_words[PHASES] = '{294, 294, 294, 294};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  mic_decimate_by_three_core uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .raw_word   (raw_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pcm_sample (pcm_sample),
    .ring_slot  (ring_slot)
  );

  pcm_average_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .raw_word    (raw_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pcm_sample  (pcm_sample),
    .ring_slot   (ring_slot),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  function automatic logic [RAW_W-1:0] word_of(input int value,
                                               input logic [SAMPLE_LSB-1:0] low_bits);
    return {value[SAMPLE_W-1:0], low_bits};
  endfunction

  function automatic logic [RAW_W-1:0] random_word();
    logic [RAW_W-1:0] word;
    word = RAW_W'($urandom);
    // keep about half the samples inside the 16-bit range
    if ($urandom_range(1) == 1) begin
      word[RAW_W-1:SAMPLE_LSB+PCM_W] = {(RAW_W-SAMPLE_LSB-PCM_W){word[SAMPLE_LSB+PCM_W-1]}};
    end
    return word;
  endfunction

  task automatic send_word(input logic [RAW_W-1:0] word);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_word <= word;
    // hold the request until taken
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (corner_samples[i]) begin
      send_word(word_of(corner_samples[i], (i % 2 == 0) ? 6'h3f : 6'h00));
      send_word((i % 2 == 0) ? 24'hffffff : 24'h000000);
    end
    for (int p = 0; p < PHASES; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      repeat (phase_words[p]) send_word(random_word());
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
